/* rtl/aewp_pkg.sv */
// Shared types and constants for the ADC event word parser.
package aewp_pkg;

   // Word type codes, found in bits 10:8 of the high half
   localparam logic [2:0] WT_DATA  = 3'd0;
   localparam logic [2:0] WT_HDR   = 3'd2;
   localparam logic [2:0] WT_TRAIL = 3'd4;

   // Queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // Configuration port
   localparam int          CSR_ADDR_W = 3;
   localparam logic        REG_GEO_EN = 1'b0;   // word index of the geo enable register

   // Front-end word phase
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_DATA    = 2'd1,
      PH_TRAILER = 2'd2
   } phase_type;

   // Classified word kinds handed from front to back
   typedef enum logic [1:0] {
      OP_HEADER     = 2'd0,
      OP_BAD_HEADER = 2'd1,
      OP_DATA       = 2'd2,
      OP_TRAILER    = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] low_half;
      logic [15:0] high_half;
   } cmd_type;

   typedef struct packed {
      logic        is_event_end;
      logic [4:0]  geo;
      logic [7:0]  crate;
      logic [4:0]  channel;
      logic [13:0] value;
      logic        word_error;
      logic        geo_ok;
      logic        trailer_ok;
      logic [5:0]  entry_count;
   } rsp_type;

endpackage

/* rtl/aewp_queue.sv */
// Small register-based first-in first-out queue.
module aewp_queue #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/aewp_front.sv */
// Front end: tracks the word phase and classifies each incoming word.
module aewp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [15:0]       req_low_half,
   input  logic [15:0]       req_high_half,
   output logic              req_full,
   output logic              cmd_push,
   output aewp_pkg::cmd_type cmd,
   input  logic              cmd_full
);
   import aewp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [5:0] words_left_ff, words_left_in;
   logic       req_accept;
   logic [2:0] word_kind;
   logic [5:0] hdr_count;

   assign req_full   = cmd_full;
   assign req_accept = req_push && !cmd_full;
   assign word_kind  = req_high_half[10:8];
   assign hdr_count  = req_low_half[13:8];

   assign cmd_push       = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         words_left_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         words_left_ff <= words_left_in;
      end
   end

   // phase sequencing and word classification
   always_comb begin
      phase_in      = phase_ff;
      words_left_in = words_left_ff;
      cmd.low_half  = req_low_half;
      cmd.high_half = req_high_half;
      cmd.op        = OP_HEADER;
      unique case (phase_ff)
         PH_DATA: begin
            cmd.op = OP_DATA;
            if (req_accept) begin
               words_left_in = words_left_ff - 1'b1;
               if (words_left_ff == 6'd1) begin
                  phase_in = PH_TRAILER;
               end
            end
         end
         PH_TRAILER: begin
            cmd.op = OP_TRAILER;
            if (req_accept) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            // expect header, also any unused code
            if (word_kind == WT_HDR) begin
               cmd.op = OP_HEADER;
               if (req_accept) begin
                  words_left_in = hdr_count;
                  phase_in      = (hdr_count != '0) ? PH_DATA : PH_TRAILER;
               end
            end else begin
               cmd.op = OP_BAD_HEADER;
               if (req_accept) begin
                  words_left_in = '0;
                  phase_in      = PH_TRAILER;
               end
            end
         end
      endcase
   end

   // data phase always has words outstanding
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> words_left_ff != '0)
      else $error("data phase with no words left");

   // in the header phase, between events, the counter is drained
   a_hdr_drained: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> words_left_ff == '0)
      else $error("header phase with words left");

   // trailer word closes the event
   a_trailer_close: assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_TRAILER) |=> phase_ff == PH_HEADER)
      else $error("trailer did not return to header phase");

endmodule

/* rtl/aewp_back.sv */
// Back end: holds event context and builds result entries into the result queue.
module aewp_back #(
   parameter int RspDepth = aewp_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       geo_enable,
   input  aewp_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output aewp_pkg::rsp_type rsp,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import aewp_pkg::*;

   logic [4:0] geo_ff, geo_in;
   logic [7:0] crate_ff, crate_in;
   logic       geo_ok_ff, geo_ok_in;
   logic [5:0] entries_ff, entries_in;
   logic       go;
   logic       rsp_full;
   logic       rsp_push;
   rsp_type    rsp_in;
   logic [4:0] hdr_geo;

   assign go      = !cmd_empty && !rsp_full;
   assign cmd_pop = go;
   assign hdr_geo = cmd.high_half[15:11];

   // execute one classified word
   always_comb begin
      geo_in     = geo_ff;
      crate_in   = crate_ff;
      geo_ok_in  = geo_ok_ff;
      entries_in = entries_ff;
      rsp_in     = '0;
      rsp_push   = 1'b0;
      if (go) begin
         unique case (cmd.op)
            OP_HEADER: begin
               entries_in = '0;
               geo_in     = hdr_geo;
               crate_in   = cmd.high_half[7:0];
               geo_ok_in  = geo_enable[hdr_geo];
            end
            OP_BAD_HEADER: begin
               geo_in            = '0;
               crate_in          = '0;
               geo_ok_in         = 1'b0;
               entries_in        = 6'd1;
               rsp_in.word_error = 1'b1;
               rsp_push          = 1'b1;
            end
            OP_DATA: begin
               if (geo_ok_ff) begin
                  entries_in    = entries_ff + 1'b1;
                  rsp_push      = 1'b1;
                  rsp_in.geo    = geo_ff;
                  rsp_in.geo_ok = 1'b1;
                  if (cmd.high_half[10:8] == WT_DATA) begin
                     rsp_in.crate   = crate_ff;
                     rsp_in.channel = cmd.high_half[4:0];
                     rsp_in.value   = cmd.low_half[13:0];
                  end else begin
                     crate_in          = '0;
                     rsp_in.word_error = 1'b1;
                  end
               end
            end
            OP_TRAILER: begin
               rsp_push            = 1'b1;
               rsp_in.is_event_end = 1'b1;
               rsp_in.geo          = geo_ff;
               rsp_in.crate        = crate_ff;
               rsp_in.geo_ok       = geo_ok_ff;
               rsp_in.trailer_ok   = (cmd.high_half[10:8] == WT_TRAIL);
               rsp_in.entry_count  = entries_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff     <= '0;
         crate_ff   <= '0;
         geo_ok_ff  <= 1'b0;
         entries_ff <= '0;
      end else begin
         geo_ff     <= geo_in;
         crate_ff   <= crate_in;
         geo_ok_ff  <= geo_ok_in;
         entries_ff <= entries_in;
      end
   end

   // result queue toward the consumer
   aewp_queue #(
      .Width ($bits(rsp_type)),
      .Depth (RspDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp),
      .empty     (rsp_empty)
   );

endmodule

/* rtl/adc_event_word_parser.sv */
// Top level of the ADC event word parser: CSR, front end, command queue, back end.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_push / req_full    req_low_half, req_high_half
//   rsp       out        rsp_empty / rsp_pop    event entry or event-end summary
//   csr       in/out     APB psel/penable       geo enable mask at byte 0
//
// One word is accepted per cycle while req_full is low; the back end executes it
// from the command queue when the result queue has room, then queues its result.
// Throughput is set by the command and result queues: both sustain one transfer
// per cycle while the consumer pops every cycle.
// Reset is synchronous; it empties both queues and clears the event context.
// A stalled consumer fills the result queue, then the command queue, then
// raises req_full.
module adc_event_word_parser #(
   parameter int CmdDepth = aewp_pkg::CMD_DEPTH,
   parameter int RspDepth = aewp_pkg::RSP_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // input words
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [15:0]                     req_low_half,
   input  logic [15:0]                     req_high_half,
   // results
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_is_event_end,
   output logic [4:0]                      rsp_geo,
   output logic [7:0]                      rsp_crate,
   output logic [4:0]                      rsp_channel,
   output logic [13:0]                     rsp_value,
   output logic                            rsp_word_error,
   output logic                            rsp_geo_ok,
   output logic                            rsp_trailer_ok,
   output logic [5:0]                      rsp_entry_count,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [aewp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import aewp_pkg::*;

   logic [31:0] geo_en_ff, geo_en_in;
   logic        csr_write;
   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     cmd_wr, cmd_rd;
   rsp_type     rsp;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      geo_en_in = geo_en_ff;
      if (csr_write && csr_paddr[2] == REG_GEO_EN) begin
         geo_en_in = csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_GEO_EN) ? geo_en_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_en_ff <= '0;
      end else begin
         geo_en_ff <= geo_en_in;
      end
   end

   aewp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_low_half  (req_low_half),
      .req_high_half (req_high_half),
      .req_full      (req_full),
      .cmd_push      (cmd_push),
      .cmd           (cmd_wr),
      .cmd_full      (cmd_full)
   );

   // decouples classification from execution
   aewp_queue #(
      .Width ($bits(cmd_type)),
      .Depth (CmdDepth)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty)
   );

   aewp_back #(
      .RspDepth (RspDepth)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .geo_enable (geo_en_ff),
      .cmd        (cmd_rd),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .rsp        (rsp),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

   assign rsp_is_event_end = rsp.is_event_end;
   assign rsp_geo          = rsp.geo;
   assign rsp_crate        = rsp.crate;
   assign rsp_channel      = rsp.channel;
   assign rsp_value        = rsp.value;
   assign rsp_word_error   = rsp.word_error;
   assign rsp_geo_ok       = rsp.geo_ok;
   assign rsp_trailer_ok   = rsp.trailer_ok;
   assign rsp_entry_count  = rsp.entry_count;

endmodule
